### src/dpcm_pkg.sv
// shared types and constants for the directional dpcm image codec
package dpcm_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int LINE_ADDR_W = $clog2(MAX_WIDTH);
    localparam int PIXEL_W     = 8;
    localparam int SAMPLE_W    = 9;
    localparam int COLUMN_W    = 10;
    localparam int IWIDTH_W    = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [IWIDTH_W-1:0] IWIDTH_MIN   = IWIDTH_W'(2);
    localparam logic [IWIDTH_W-1:0] IWIDTH_MAX   = IWIDTH_W'(MAX_WIDTH);
    localparam logic [IWIDTH_W-1:0] IWIDTH_RESET = IWIDTH_W'(MAX_WIDTH);

    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_DECODE_MODE = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = CFG_INDEX_W'(2);

    typedef enum logic [1:0] {
        DIR_LEFT,
        DIR_ABOVE,
        DIR_UPPER_LEFT,
        DIR_UPPER_RIGHT
    } dir_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [COLUMN_W-1:0]        column;
        logic                       first_row;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] result;
        logic                       is_master;
    } out_item_t;

endpackage

### src/dpcm_ram.sv
// generic ram, one write port and two registered read ports
module dpcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

### src/directional_dpcm_image_codec.sv
// directional dpcm image coder and decoder, top level
// Codes one pixel per clock: a new pixel is taken in every cycle while the
// result side does not stall, and its result reaches the output register
// through the read stage (the transfer edge starts the line memory read and
// loads the read stage, which registers the prediction and the result once
// the output side is free). Throughput is set by the line memory, which
// serves the above pixel and the side neighbour through two read ports and
// takes the coded pixel back through its write port in the same cycle; the
// pixel written by the previous item is forwarded. The line memory is not
// cleared after reset: each column must be written by the first row before
// a later row reads it. Configuration must be written only while no pixel
// is in flight.
module directional_dpcm_image_codec (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  dpcm_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output dpcm_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dpcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dpcm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import dpcm_pkg::*;

    dir_t                   direction_reg, direction_next;
    logic                   decode_mode_reg, decode_mode_next;
    logic [IWIDTH_W-1:0]    image_width_reg, image_width_next;
    logic [IWIDTH_W-1:0]    width_eff;
    logic [LINE_ADDR_W-1:0] last_col;

    logic                   in_accept;
    logic                   s1_go;
    logic [LINE_ADDR_W-1:0] here_addr;
    logic [LINE_ADDR_W-1:0] side_addr;

    logic                   s1_valid_reg, s1_valid_next;
    in_item_t               s1_item_reg;
    logic [LINE_ADDR_W-1:0] s1_here_reg;
    logic [LINE_ADDR_W-1:0] s1_side_reg;

    logic [PIXEL_W-1:0]     rd_above;
    logic [PIXEL_W-1:0]     rd_side;
    logic [PIXEL_W-1:0]     above;
    logic [PIXEL_W-1:0]     side;
    logic [PIXEL_W-1:0]     neighbour;
    logic [PIXEL_W-1:0]     pixel;
    logic                   master;
    logic [SAMPLE_W-1:0]    res;

    logic                   wr_valid_reg, wr_valid_next;
    logic [LINE_ADDR_W-1:0] wr_addr_reg;
    logic [PIXEL_W-1:0]     wr_data_reg;
    logic [PIXEL_W-1:0]     displaced_reg, displaced_next;

    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_item_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_comb
    begin
        direction_next   = direction_reg;
        decode_mode_next = decode_mode_reg;
        image_width_next = image_width_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DIRECTION:   direction_next   = dir_t'(cfg_data[1:0]);
                CFG_DECODE_MODE: decode_mode_next = cfg_data[0];
                CFG_IMAGE_WIDTH: image_width_next = cfg_data[IWIDTH_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (image_width_reg < IWIDTH_MIN)
        begin
            width_eff = IWIDTH_MIN;
        end
        else if (image_width_reg > IWIDTH_MAX)
        begin
            width_eff = IWIDTH_MAX;
        end
        else
        begin
            width_eff = image_width_reg;
        end
    end

    assign last_col = LINE_ADDR_W'(width_eff - IWIDTH_W'(1));

    // handshake and stage control
    assign s1_go     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;

    assign here_addr = LINE_ADDR_W'(in_data.column);
    assign side_addr = (direction_reg == DIR_UPPER_RIGHT)
                       ? here_addr + LINE_ADDR_W'(1)
                       : here_addr - LINE_ADDR_W'(1);

    dpcm_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk       (clk),
        .wr_en     (s1_go),
        .wr_addr   (s1_here_reg),
        .wr_data   (pixel),
        .rd_en     (in_accept),
        .rd_addr_a (here_addr),
        .rd_addr_b (side_addr),
        .rd_data_a (rd_above),
        .rd_data_b (rd_side)
    );

    // forward the write made at the read edge
    assign above = (wr_valid_reg && wr_addr_reg == s1_here_reg) ? wr_data_reg : rd_above;
    assign side  = (wr_valid_reg && wr_addr_reg == s1_side_reg) ? wr_data_reg : rd_side;

    always_comb
    begin
        master    = 1'b0;
        neighbour = side;
        if (s1_item_reg.first_row)
        begin
            if (direction_reg == DIR_UPPER_RIGHT)
            begin
                master = (s1_here_reg == last_col);
            end
            else
            begin
                master = (s1_here_reg == '0);
            end
        end
        else
        begin
            case (direction_reg)
                DIR_LEFT:        neighbour = (s1_here_reg == '0) ? above : side;
                DIR_ABOVE:       neighbour = above;
                DIR_UPPER_LEFT:  neighbour = (s1_here_reg == '0) ? above : displaced_reg;
                DIR_UPPER_RIGHT: neighbour = (s1_here_reg == last_col) ? above : side;
                default:         neighbour = above;
            endcase
        end
    end

    always_comb
    begin
        if (!master && decode_mode_reg)
        begin
            pixel = neighbour - s1_item_reg.sample[PIXEL_W-1:0];
            res   = {1'b0, pixel};
        end
        else if (master)
        begin
            pixel = s1_item_reg.sample[PIXEL_W-1:0];
            res   = {1'b0, pixel};
        end
        else
        begin
            pixel = s1_item_reg.sample[PIXEL_W-1:0];
            res   = {1'b0, neighbour} - {1'b0, pixel};
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign wr_valid_next  = s1_go ? 1'b1 : wr_valid_reg;
    assign displaced_next = s1_go ? above : displaced_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg   <= DIR_LEFT;
            decode_mode_reg <= 1'b0;
            image_width_reg <= IWIDTH_RESET;
            s1_valid_reg    <= 1'b0;
            wr_valid_reg    <= 1'b0;
            displaced_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            direction_reg   <= direction_next;
            decode_mode_reg <= decode_mode_next;
            image_width_reg <= image_width_next;
            s1_valid_reg    <= s1_valid_next;
            wr_valid_reg    <= wr_valid_next;
            displaced_reg   <= displaced_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg <= in_data;
            s1_here_reg <= here_addr;
            s1_side_reg <= side_addr;
        end
        if (s1_go)
        begin
            wr_addr_reg            <= s1_here_reg;
            wr_data_reg            <= pixel;
            out_item_reg.result    <= res;
            out_item_reg.is_master <= master;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // checks
    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted pixel did not reach the read stage");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_here_reg)))
        else $error("stalled read stage lost its pixel");

    a_write_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go |=> (wr_valid_reg && wr_addr_reg == $past(s1_here_reg)))
        else $error("forwarding register missed a line write");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go |=> out_valid_reg)
        else $error("coded pixel did not reach the output register");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled while the output side was free");

endmodule
